// ===== sv/rpn_stack_integer_calculator_top_defines.svh =====
// Assertion macros for the RPN calculator checker.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef RPN_STACK_INTEGER_CALCULATOR_TOP_DEFINES_SVH
`define RPN_STACK_INTEGER_CALCULATOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RPN_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn checker: same-cycle property failed");

// next-cycle implication, off during reset
`define RPN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn checker: next-cycle property failed");

// next-cycle implication, always active
`define RPN_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rpn checker: reset property failed");

`endif

// ===== sv/rpn_pkg.sv =====
// Shared types for the RPN calculator: opcodes, payload structs, FSM states,
// controller/datapath command and status structs. No dependencies.
package rpn_pkg;

  typedef enum logic [3:0] {
    OP_PUSH      = 4'd0,
    OP_ADD       = 4'd1,
    OP_SUB       = 4'd2,
    OP_MUL       = 4'd3,
    OP_DIV       = 4'd4,
    OP_POW       = 4'd5,
    OP_LOG       = 4'd6,
    OP_SQRT      = 4'd7,
    OP_SELECT    = 4'd8,
    OP_END_LINE  = 4'd9,
    OP_BAD_TOKEN = 4'd10
  } opcode_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] number;
  } in_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic               failed;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_DECODE = 4'd1,
    S_LD_L   = 4'd2,
    S_LD_R   = 4'd3,
    S_LD_C   = 4'd4,
    S_START  = 4'd5,
    S_BUSY   = 4'd6,
    S_LD_END = 4'd7,
    S_EMIT   = 4'd8
  } state_t;

  typedef struct packed {
    logic load_in;
    logic pop;
    logic cap_l;
    logic cap_r;
    logic cap_c;
    logic set_err;
    logic push_num;
    logic push_res;
    logic iter_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    err;
    logic    has1;
    logic    has2;
    logic    has3;
    logic    full;
    logic    oper_bad;
    logic    simple_op;
    logic    iter_done;
    logic    out_free;
  } stat_t;

endpackage

// ===== sv/rpn_stack_integer_calculator_top.sv =====
// Top level of the RPN stack integer calculator.
// Depends on rpn_pkg, rpn_ctrl, rpn_dp (which holds rpn_ram and rpn_iter).
//
//   channel  | ports                          | carries
//   ---------+--------------------------------+------------------------------
//   in       | in_valid, in_ready, in_data    | one token: opcode, number
//   out      | out_valid, out_ready, out_data | end-of-line answer, failed
//
// Push, bad token, ignored tokens and missing operands are settled in decode;
// add, sub and select read their operands and then push the result; mul, div,
// sqrt, log and pow run in rpn_iter (pow makes two multiplier passes per
// exponent bit). The shared 32x32 multiplier and the one-read-port stack RAM
// set the pace: operands are read one per cycle.
// Reset (rst_n low, synchronous) empties the stack and clears the error
// flag; stack contents are not cleared. A stalled result sits in the output
// register while later tokens are still taken; only a second end of line
// waits for that register to drain.
module rpn_stack_integer_calculator_top import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t  cmd;   // controller -> datapath
  stat_t stat;  // datapath -> controller

  // token sequencing
  rpn_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // stack, arithmetic and output register
  rpn_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== sv/rpn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rpn_iter.sv =====
// Multi-cycle arithmetic unit: mul, div, pow, floor log, floor sqrt.
// Depends on rpn_pkg. One shared 32x32 multiplier.
module rpn_iter import rpn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  opcode_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] res
);

  opcode_t     op_r, op_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;
  logic [63:0] w0_r, w0_nxt;
  logic [31:0] w1_r, w1_nxt;
  logic [31:0] w2_r, w2_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        ph_r, ph_nxt;
  logic        neg_r, neg_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [32:0] rem_sh, rem_sub;
  logic [31:0] sq_t;
  logic [31:0] abs_a, abs_b;

  always_comb begin
    mul_a = w1_r;
    mul_b = w2_r;
    case (op_r)
      OP_POW: begin
        mul_a = ph_r ? w1_r : w0_r[31:0];
        mul_b = w1_r;
      end
      OP_LOG: begin
        mul_a = w0_r[31:0];
        mul_b = w2_r;
      end
      default: ;
    endcase
  end

  assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
  assign abs_a   = a[31] ? (~a + 32'd1) : a;
  assign abs_b   = b[31] ? (~b + 32'd1) : b;
  assign rem_sh  = {w0_r[31:0], w1_r[31]};
  assign rem_sub = rem_sh - {1'b0, w2_r};
  assign sq_t    = w1_r + w2_r;

  always_comb begin
    op_nxt   = op_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    w0_nxt   = w0_r;
    w1_nxt   = w1_r;
    w2_nxt   = w2_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    neg_nxt  = neg_r;
    if (start && !run_r) begin
      op_nxt  = op;
      run_nxt = 1'b1;
      case (op)
        OP_MUL: begin
          w1_nxt = a;
          w2_nxt = b;
        end
        OP_POW: begin
          w0_nxt = 64'd1;
          w1_nxt = a;
          w2_nxt = b;
          ph_nxt = 1'b0;
        end
        OP_DIV: begin
          neg_nxt = a[31] ^ b[31];
          w0_nxt  = '0;
          w1_nxt  = abs_a;
          w2_nxt  = abs_b;
          cnt_nxt = 6'd32;
        end
        OP_SQRT: begin
          w0_nxt = {32'd0, a};
          w1_nxt = '0;
          w2_nxt = 32'h4000_0000;
        end
        OP_LOG: begin
          if ($signed(a) < $signed(b)) begin
            // value below the base: answer is zero
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = '0;
          end else begin
            w0_nxt  = {32'd0, b};
            w1_nxt  = a;
            w2_nxt  = b;
            cnt_nxt = '0;
          end
        end
        default: begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = '0;
        end
      endcase
    end else if (run_r) begin
      case (op_r)
        OP_MUL: begin
          res_nxt  = prod[31:0];
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
        OP_POW: begin
          if (w2_r == 32'd0) begin
            res_nxt  = w0_r[31:0];
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
          end else if (!ph_r) begin
            if (w2_r[0]) begin
              w0_nxt = {32'd0, prod[31:0]};
            end
            ph_nxt = 1'b1;
          end else begin
            w1_nxt = prod[31:0];
            w2_nxt = w2_r >> 1;
            ph_nxt = 1'b0;
          end
        end
        OP_DIV: begin
          if (cnt_r == 6'd0) begin
            res_nxt  = neg_r ? (~w1_r + 32'd1) : w1_r;
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
          end else begin
            if (rem_sh >= {1'b0, w2_r}) begin
              w0_nxt = {32'd0, rem_sub[31:0]};
              w1_nxt = {w1_r[30:0], 1'b1};
            end else begin
              w0_nxt = {32'd0, rem_sh[31:0]};
              w1_nxt = {w1_r[30:0], 1'b0};
            end
            cnt_nxt = cnt_r - 6'd1;
          end
        end
        OP_SQRT: begin
          if (w2_r == 32'd0) begin
            res_nxt  = w1_r;
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
          end else begin
            if (w0_r[31:0] >= sq_t) begin
              w0_nxt = {32'd0, w0_r[31:0] - sq_t};
              w1_nxt = (w1_r >> 1) + w2_r;
            end else begin
              w1_nxt = w1_r >> 1;
            end
            w2_nxt = w2_r >> 2;
          end
        end
        OP_LOG: begin
          // power stays below 2^31 whenever it is multiplied again
          if (w0_r <= {32'd0, w1_r}) begin
            cnt_nxt = cnt_r + 6'd1;
            w0_nxt  = prod;
          end else begin
            res_nxt  = {26'd0, cnt_r};
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          res_nxt  = '0;
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
    w0_r  <= w0_nxt;
    w1_r  <= w1_nxt;
    w2_r  <= w2_nxt;
    cnt_r <= cnt_nxt;
    ph_r  <= ph_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== sv/rpn_dp.sv =====
// Datapath: operand stack RAM, count, error flag, operand registers,
// arithmetic unit and output register. Depends on rpn_pkg, rpn_ram, rpn_iter.
module rpn_dp import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  output stat_t stat,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt, cnt_m1;
  logic          err_r, err_nxt;
  logic [3:0]    op_r;
  logic [31:0]   num_r, l_r, r_r, c_r;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;
  opcode_t       op_e;

  logic          we;
  logic [31:0]   wdata, rdata, simple_res, iter_res;
  logic          iter_done;
  logic          fail;
  logic          oper_bad;

  assign op_e   = opcode_t'(op_r);
  assign cnt_m1 = cnt_r - CW'(1);
  assign we     = cmd.push_num | cmd.push_res;

  always_comb begin
    case (op_e)
      OP_ADD:    simple_res = l_r + r_r;
      OP_SUB:    simple_res = l_r - r_r;
      default:   simple_res = (l_r == 32'd0) ? c_r : r_r;
    endcase
  end

  assign wdata = cmd.push_num ? num_r :
                 (stat.simple_op ? simple_res : iter_res);

  rpn_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(cnt_r[AW-1:0]),
    .wdata(wdata),
    .raddr(cnt_m1[AW-1:0]),
    .rdata(rdata)
  );

  rpn_iter u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.iter_start),
    .op   (op_e),
    .a    (l_r),
    .b    (r_r),
    .done (iter_done),
    .res  (iter_res)
  );

  // operand checks on captured L (top) and R (next)
  always_comb begin
    case (op_e)
      OP_DIV:  oper_bad = (r_r == 32'd0);
      OP_POW:  oper_bad = r_r[31] || ((l_r == 32'd0) && (r_r == 32'd0));
      OP_LOG:  oper_bad = ($signed(r_r) <= $signed(32'sd1));
      OP_SQRT: oper_bad = l_r[31];
      default: oper_bad = 1'b0;
    endcase
  end

  assign stat.op        = op_e;
  assign stat.err       = err_r;
  assign stat.has1      = (cnt_r >= CW'(1));
  assign stat.has2      = (cnt_r >= CW'(2));
  assign stat.has3      = (cnt_r >= CW'(3));
  assign stat.full      = (cnt_r == CW'(STACK_DEPTH));
  assign stat.oper_bad  = oper_bad;
  assign stat.simple_op = (op_e == OP_ADD) || (op_e == OP_SUB) || (op_e == OP_SELECT);
  assign stat.iter_done = iter_done;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign fail = err_r || (cnt_r != CW'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (cmd.load_out) begin
      cnt_nxt = '0;
      err_nxt = 1'b0;
    end else begin
      if (cmd.pop) begin
        cnt_nxt = cnt_m1;
      end else if (we) begin
        cnt_nxt = cnt_r + CW'(1);
      end
      if (cmd.set_err) begin
        err_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_nxt.failed = fail;
      out_nxt.answer = fail ? 32'sd0 : $signed(l_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.load_in) begin
      op_r  <= in_data.opcode;
      num_r <= in_data.number;
    end
    if (cmd.cap_l) begin
      l_r <= rdata;
    end
    if (cmd.cap_r) begin
      r_r <= rdata;
    end
    if (cmd.cap_c) begin
      c_r <= rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/rpn_ctrl.sv =====
// Controller FSM: decodes tokens, sequences stack reads, operator execution
// and end-of-line output. Depends on rpn_pkg.
module rpn_ctrl import rpn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (stat.op == OP_END_LINE) begin
          state_nxt = S_LD_END;
        end else if (stat.err) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (stat.op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW, OP_LOG:
              state_nxt = stat.has2 ? S_LD_L : S_IDLE;
            OP_SQRT:   state_nxt = stat.has1 ? S_LD_L : S_IDLE;
            OP_SELECT: state_nxt = stat.has3 ? S_LD_L : S_IDLE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_L:   state_nxt = (stat.op == OP_SQRT) ? S_START : S_LD_R;
      S_LD_R:   state_nxt = (stat.op == OP_SELECT) ? S_LD_C : S_START;
      S_LD_C:   state_nxt = S_START;
      S_START: begin
        if (stat.oper_bad || stat.simple_op) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_BUSY;
        end
      end
      S_BUSY:   if (stat.iter_done) state_nxt = S_IDLE;
      S_LD_END: state_nxt = S_EMIT;
      S_EMIT:   if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        if ((stat.op != OP_END_LINE) && !stat.err) begin
          unique case (stat.op) inside
            OP_PUSH: begin
              cmd.set_err  = stat.full;
              cmd.push_num = !stat.full;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW, OP_LOG: begin
              cmd.pop     = stat.has2;
              cmd.set_err = !stat.has2;
            end
            OP_SQRT: begin
              cmd.pop     = stat.has1;
              cmd.set_err = !stat.has1;
            end
            OP_SELECT: begin
              cmd.pop     = stat.has3;
              cmd.set_err = !stat.has3;
            end
            default: cmd.set_err = 1'b1;
          endcase
        end
      end
      S_LD_L: begin
        cmd.cap_l = 1'b1;
        cmd.pop   = (stat.op != OP_SQRT);
      end
      S_LD_R: begin
        cmd.cap_r = 1'b1;
        cmd.pop   = (stat.op == OP_SELECT);
      end
      S_LD_C:   cmd.cap_c = 1'b1;
      S_START: begin
        if (stat.oper_bad) begin
          cmd.set_err = 1'b1;
        end else if (stat.simple_op) begin
          cmd.push_res = 1'b1;
        end else begin
          cmd.iter_start = 1'b1;
        end
      end
      S_BUSY:   cmd.push_res = stat.iter_done;
      S_LD_END: cmd.cap_l = 1'b1;
      S_EMIT:   cmd.load_out = stat.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/rpn_chk.sv =====
// Port-level checker for the RPN calculator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_integer_calculator_top_defines.svh.
`include "rpn_stack_integer_calculator_top_defines.svh"

module rpn_chk import rpn_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // stalled result holds
  `RPN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a failed line reports zero
  `RPN_ASSERT_SAME(a_fail_zero, out_valid && out_data.failed, out_data.answer == 32'sd0)

  // one token at a time: ready drops after each transaction
  `RPN_ASSERT_NEXT(a_one_token, in_valid && in_ready, !in_ready)

  // reset empties the output register
  `RPN_ASSERT_NEXT_ALWAYS(a_reset_out, !rst_n, !out_valid)

endmodule

bind rpn_stack_integer_calculator_top rpn_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
